>>> rtl/cslw_pkg.sv
// ----------------------------------------------------------------------------
// cslw_pkg
// Shared types and constants for the LRU write-back cache set.
// ----------------------------------------------------------------------------
package cslw_pkg;

   localparam int WAYS     = 4;
   localparam int TAG_BITS = 32;
   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

   // request / response field widths
   localparam int REQ_TAG_W  = 32;
   localparam int OUTCOME_W  = 2;
   localparam int WAY_OUT_W  = 2;
   localparam int RSP_DATA_W = 8;

   typedef logic [TAG_BITS-1:0]  tag_type;
   typedef logic [WAY_BITS-1:0]  way_type;
   typedef logic [WAY_BITS-1:0]  rank_type;
   typedef logic [OUTCOME_W-1:0] outcome_type;

   localparam outcome_type OUT_HIT        = 2'd0;
   localparam outcome_type OUT_MISS       = 2'd1;
   localparam outcome_type OUT_MISS_DIRTY = 2'd2;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COMMIT
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load_req;  // capture request
      logic lookup;    // register hit / victim decision
      logic commit;    // update set state, load response register
   } dp_cmd_type;

endpackage

>>> rtl/cache_set_lru_writeback_unit.sv
// ----------------------------------------------------------------------------
// cache_set_lru_writeback_unit
// One set of a write-back, set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Each request transfer carries a read/write command (req_tuser) and a line
// tag (req_tdata) and yields exactly one response transfer: the outcome (hit,
// miss, or miss evicting a dirty line) and the way that hit or was filled.
// Misses fill the lowest invalid way, else the least recently used way; a
// write marks the way dirty, a read fill leaves it clean. An access steps
// through the controller states accept, lookup and commit, and a new request
// is taken only once the previous access has committed; the response sits in
// an output register, and a new request is taken while it waits. A commit
// stalls only while the previous response is still untaken. No clearing pass
// follows reset: the set is empty and ready as soon as reset is released.
// ----------------------------------------------------------------------------
module cache_set_lru_writeback_unit
   import cslw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_TAG_W-1:0]  req_tdata,   // [31:0] access_tag
   input  logic                  req_tuser,   // [0] cmd (0 read, 1 write)
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [1:0] outcome, [3:2] way_used
);

   dp_cmd_type dp_cmd;

   // sequencer: one access in flight at a time
   cslw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd)
   );

   // way state, tag compare, LRU ranks and response payload
   cslw_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .req_cmd        (req_tuser),
      .req_access_tag (req_tdata),
      .rsp_data       (rsp_tdata)
   );

endmodule

>>> rtl/cslw_ctrl.sv
// ----------------------------------------------------------------------------
// cslw_ctrl
// Access sequencer: accept, look up, commit; owns the response valid flag.
// ----------------------------------------------------------------------------
module cslw_ctrl
   import cslw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type dp_cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // response register can take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      dp_cmd.load_req = 1'b0;
      dp_cmd.lookup   = 1'b0;
      dp_cmd.commit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready      = 1'b1;
            dp_cmd.load_req = req_tvalid;
         end
         ST_LOOKUP: begin
            dp_cmd.lookup = 1'b1;
         end
         ST_COMMIT: begin
            dp_cmd.commit = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (dp_cmd.commit) rsp_valid_in = 1'b1;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/cslw_datapath.sv
// ----------------------------------------------------------------------------
// cslw_datapath
// Way state (valid, dirty, tag, recency rank), lookup and response payload.
// ----------------------------------------------------------------------------
module cslw_datapath
   import cslw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             dp_cmd,
   input  logic                   req_cmd,
   input  logic [REQ_TAG_W-1:0]   req_access_tag,
   output logic [RSP_DATA_W-1:0]  rsp_data
);

   logic        valid_ff [WAYS];
   logic        dirty_ff [WAYS];
   tag_type     tag_ff   [WAYS];
   rank_type    rank_ff  [WAYS];

   logic        cmd_ff;
   tag_type     req_tag_ff;

   logic        hit_ff, hit_in;
   way_type     way_ff, way_in;
   logic        evict_dirty_ff, evict_dirty_in;

   outcome_type outcome_ff;
   way_type     rsp_way_ff;

   logic        any_free;
   way_type     hit_way, free_way, old_way;
   rank_type    touched_rank;

   // parallel compare; loop runs high to low so the lowest way wins
   always_comb begin
      hit_in   = 1'b0;
      any_free = 1'b0;
      hit_way  = '0;
      free_way = '0;
      old_way  = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == req_tag_ff)) begin
            hit_in  = 1'b1;
            hit_way = way_type'(i);
         end
         if (!valid_ff[i]) begin
            any_free = 1'b1;
            free_way = way_type'(i);
         end
         if (rank_ff[i] == '0) old_way = way_type'(i);
      end
      if (hit_in)        way_in = hit_way;
      else if (any_free) way_in = free_way;
      else               way_in = old_way;
      evict_dirty_in = !hit_in && !any_free && dirty_ff[old_way];
   end

   assign touched_rank = rank_ff[way_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WAYS; i++) begin
            valid_ff[i] <= 1'b0;
            dirty_ff[i] <= 1'b0;
            tag_ff[i]   <= '1;
            rank_ff[i]  <= rank_type'(i);
         end
      end else if (dp_cmd.commit) begin
         for (int i = 0; i < WAYS; i++) begin
            if (way_type'(i) == way_ff) begin
               rank_ff[i] <= rank_type'(WAYS - 1);
            end else if (rank_ff[i] > touched_rank) begin
               rank_ff[i] <= rank_ff[i] - rank_type'(1);
            end
         end
         if (hit_ff) begin
            if (cmd_ff == CMD_WRITE) dirty_ff[way_ff] <= 1'b1;
         end else begin
            valid_ff[way_ff] <= 1'b1;
            dirty_ff[way_ff] <= (cmd_ff == CMD_WRITE);
            tag_ff[way_ff]   <= req_tag_ff;
         end
      end
   end

   // request and decision registers; payload only
   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         cmd_ff     <= req_cmd;
         req_tag_ff <= tag_type'(req_access_tag);
      end
      if (dp_cmd.lookup) begin
         hit_ff         <= hit_in;
         way_ff         <= way_in;
         evict_dirty_ff <= evict_dirty_in;
      end
      if (dp_cmd.commit) begin
         rsp_way_ff <= way_ff;
         if (hit_ff)              outcome_ff <= OUT_HIT;
         else if (evict_dirty_ff) outcome_ff <= OUT_MISS_DIRTY;
         else                     outcome_ff <= OUT_MISS;
      end
   end

   assign rsp_data = {{(RSP_DATA_W - OUTCOME_W - WAY_OUT_W){1'b0}},
                      WAY_OUT_W'(rsp_way_ff), outcome_ff};

endmodule

>>> rtl/cslw_checker.sv
// ----------------------------------------------------------------------------
// cslw_checker
// Port-level checks for the cache set, bound to the top level.
// ----------------------------------------------------------------------------
module cslw_checker
   import cslw_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // outcome code three never produced, pad bits zero
   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3) && (rsp_tdata[7:4] == 4'd0))
      else $error("bad response encoding");

   // one access in flight: no request taken right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("request accepted while busy");

   // a new response only appears while an access was in flight
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response without an access");

endmodule

bind cache_set_lru_writeback_unit cslw_checker u_cslw_checker (.*);
